// File: sv/sdo_pkg.sv
// shared types, codes and helpers of the sdo transaction table
package sdo_pkg;

   localparam int ENTRIES_DEF = 32;

   // input operation codes
   localparam logic [2:0] OP_DEFINE     = 3'd0;
   localparam logic [2:0] OP_READ       = 3'd1;
   localparam logic [2:0] OP_WRITE      = 3'd2;
   localparam logic [2:0] OP_READ_OK    = 3'd3;
   localparam logic [2:0] OP_READ_FAIL  = 3'd4;
   localparam logic [2:0] OP_WRITE_OK   = 3'd5;
   localparam logic [2:0] OP_WRITE_FAIL = 3'd6;
   localparam logic [2:0] OP_TICK       = 3'd7;

   // result kinds
   localparam logic [2:0] KIND_ACK      = 3'd0;
   localparam logic [2:0] KIND_BUSY     = 3'd1;
   localparam logic [2:0] KIND_UNKNOWN  = 3'd2;
   localparam logic [2:0] KIND_BAD      = 3'd3;
   localparam logic [2:0] KIND_READ_REQ = 3'd4;
   localparam logic [2:0] KIND_WR_REQ   = 3'd5;
   localparam logic [2:0] KIND_COMPLETE = 3'd6;
   localparam logic [2:0] KIND_FLUSH    = 3'd7;

   // transaction modes
   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // transaction phases
   localparam logic [1:0] PH_SUCCESS = 2'd0;
   localparam logic [1:0] PH_READING = 2'd1;
   localparam logic [1:0] PH_WRITING = 2'd2;
   localparam logic [1:0] PH_CONFIRM = 2'd3;

   // one table entry, flags bit 0 masked, bit 1 notify
   typedef struct packed {
      logic [1:0]  mode;
      logic [1:0]  phase;
      logic [1:0]  flags;
      logic        live;
      logic [23:0] key;
      logic [1:0]  size;
      logic [63:0] data;
      logic [31:0] version;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type rec;
   } ram_wr_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_REPLY
   } seq_state_type;

   function automatic logic [63:0] size_mask(input logic [1:0] code);
      logic [63:0] m;
      unique case (code)
         2'd0:    m = 64'h0000_0000_0000_00ff;
         2'd1:    m = 64'h0000_0000_0000_ffff;
         2'd2:    m = 64'h0000_0000_ffff_ffff;
         default: m = 64'hffff_ffff_ffff_ffff;
      endcase
      return m;
   endfunction

endpackage

// File: sv/sdo_entry_ram.sv
// entry memory with per-entry valid bits, registered read
module sdo_entry_ram #(
   parameter int ENTRIES = sdo_pkg::ENTRIES_DEF,
   parameter int AW      = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output sdo_pkg::entry_type rd_rec,
   input  sdo_pkg::ram_wr_type wr,
   input  logic [AW-1:0]      wr_addr
);

   sdo_pkg::entry_type mem_ff [ENTRIES];
   sdo_pkg::entry_type rd_data_ff;
   logic [ENTRIES-1:0] vld_ff;
   logic               rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr_addr] <= wr.rec;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // an entry never written reads as its reset value
   assign rd_rec = rd_vld_ff ? rd_data_ff : '0;

endmodule

// File: sv/sdo_transaction_table.sv
// sdo transaction table top level: sequencer over the entry memory
//
//   channel  dir  handshake          payload
//   req_     in   req_valid/ready    operation, entry, key, size, masked, data, checked
//   rsp_     out  rsp_valid/ready    kind, entry, request key/size, value, version, last
//
// each entry visit is a memory read, then evaluate and write back
// a tick sweeps every entry and ends with a flush result marked last
// req_ready is high only in idle; a held result stalls the sequencer in place
// synchronous reset clears the valid bits of all entries at once
module sdo_transaction_table #(
   parameter int ENTRIES = sdo_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [4:0]  req_entry_id,
   input  logic [15:0] req_obj_index,
   input  logic [7:0]  req_obj_subindex,
   input  logic [1:0]  req_size_code,
   input  logic        req_masked,
   input  logic [63:0] req_data_value,
   input  logic        req_checked,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [4:0]  rsp_result_entry,
   output logic [15:0] rsp_req_index,
   output logic [7:0]  rsp_req_subindex,
   output logic [1:0]  rsp_req_size,
   output logic [63:0] rsp_out_value,
   output logic [31:0] rsp_out_version,
   output logic        rsp_last
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [AW-1:0] LAST_PTR = AW'(ENTRIES - 1);

   sdo_pkg::seq_state_type state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          sweep_ff, sweep_in;
   logic [2:0]    reply_kind_ff, reply_kind_in;

   logic [2:0]  op_ff;
   logic [4:0]  id_ff;
   logic [23:0] key_ff;
   logic [1:0]  size_ff;
   logic        masked_ff;
   logic [63:0] data_ff;
   logic        checked_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_kind_ff;
   logic [4:0]  rsp_entry_ff;
   logic [15:0] rsp_index_ff;
   logic [7:0]  rsp_sub_ff;
   logic [1:0]  rsp_size_ff;
   logic [63:0] rsp_value_ff;
   logic [31:0] rsp_version_ff;
   logic        rsp_last_ff;

   sdo_pkg::entry_type  rd_rec, new_rec;
   sdo_pkg::ram_wr_type ram_wr;
   logic                rd_en;

   logic        out_free, want_emit, emit_en, do_wr;
   logic [2:0]  emit_kind;
   logic [4:0]  emit_entry;
   logic [15:0] emit_index;
   logic [7:0]  emit_sub;
   logic [1:0]  emit_size;
   logic [63:0] emit_value;
   logic [31:0] emit_version;
   logic        emit_last;

   logic        req_accept, id_bad, key_hit, busy;
   logic [63:0] resp_mask, resp_val;
   logic [31:0] ver_inc;
   logic [1:0]  tick_phase;

   sdo_entry_ram #(
      .ENTRIES(ENTRIES),
      .AW     (AW)
   ) u_ram (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_addr(ptr_ff),
      .rd_rec (rd_rec),
      .wr     (ram_wr),
      .wr_addr(ptr_ff)
   );

   assign req_ready  = (state_ff == sdo_pkg::S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign id_bad     = 7'(req_entry_id) >= 7'(ENTRIES);
   assign key_hit    = rd_rec.live && (rd_rec.key == key_ff);
   assign busy       = rd_rec.mode != sdo_pkg::MODE_NONE;
   assign resp_mask  = sdo_pkg::size_mask(size_ff);
   assign resp_val   = data_ff & resp_mask;
   assign ver_inc    = rd_rec.version + 32'd1;
   assign tick_phase = rd_rec.flags[0] ? sdo_pkg::PH_SUCCESS : rd_rec.phase;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      sweep_in      = sweep_ff;
      reply_kind_in = reply_kind_ff;
      rd_en         = 1'b0;
      new_rec       = rd_rec;
      do_wr         = 1'b0;
      want_emit     = 1'b0;
      emit_en       = 1'b0;
      emit_kind     = sdo_pkg::KIND_ACK;
      emit_entry    = 5'(ptr_ff);
      emit_index    = '0;
      emit_sub      = '0;
      emit_size     = '0;
      emit_value    = '0;
      emit_version  = '0;
      emit_last     = 1'b1;
      ram_wr.en     = 1'b0;
      ram_wr.rec    = new_rec;

      unique case (state_ff)
         sdo_pkg::S_IDLE: begin
            if (req_accept) begin
               ptr_in   = '0;
               sweep_in = 1'b1;
               state_in = sdo_pkg::S_READ;
               if (req_operation == sdo_pkg::OP_DEFINE ||
                   req_operation == sdo_pkg::OP_READ ||
                   req_operation == sdo_pkg::OP_WRITE) begin
                  if (id_bad) begin
                     reply_kind_in = sdo_pkg::KIND_BAD;
                     state_in      = sdo_pkg::S_REPLY;
                  end else if (req_operation != sdo_pkg::OP_DEFINE) begin
                     ptr_in = AW'(req_entry_id);
                  end
               end
            end
         end

         sdo_pkg::S_READ: begin
            rd_en    = 1'b1;
            state_in = sdo_pkg::S_EVAL;
         end

         sdo_pkg::S_EVAL: begin
            unique case (op_ff) inside
               sdo_pkg::OP_DEFINE: begin
                  if (sweep_ff) begin
                     // latest define owns the key
                     if (key_hit) begin
                        new_rec.live = 1'b0;
                        do_wr        = 1'b1;
                     end
                  end else begin
                     new_rec.key   = key_ff;
                     new_rec.live  = 1'b1;
                     new_rec.size  = size_ff;
                     new_rec.flags = {rd_rec.flags[1], masked_ff};
                     do_wr         = 1'b1;
                     want_emit     = 1'b1;
                  end
               end
               sdo_pkg::OP_READ, sdo_pkg::OP_WRITE: begin
                  want_emit = 1'b1;
                  if (busy && checked_ff) begin
                     emit_kind = sdo_pkg::KIND_BUSY;
                  end else begin
                     do_wr = 1'b1;
                     if (op_ff == sdo_pkg::OP_WRITE) begin
                        new_rec.data = data_ff;
                     end
                     if (!busy) begin
                        new_rec.mode  = (op_ff == sdo_pkg::OP_READ) ?
                                        sdo_pkg::MODE_READ : sdo_pkg::MODE_WRITE;
                        new_rec.phase = (op_ff == sdo_pkg::OP_READ) ?
                                        sdo_pkg::PH_READING : sdo_pkg::PH_WRITING;
                        new_rec.flags = {checked_ff, rd_rec.flags[0]};
                     end
                  end
               end
               sdo_pkg::OP_TICK: begin
                  if (busy) begin
                     do_wr         = 1'b1;
                     new_rec.phase = tick_phase;
                     emit_last     = 1'b0;
                     if (tick_phase == sdo_pkg::PH_SUCCESS) begin
                        new_rec.mode = sdo_pkg::MODE_NONE;
                        want_emit    = rd_rec.flags[1];
                        emit_kind    = sdo_pkg::KIND_COMPLETE;
                        emit_value   = rd_rec.data;
                        emit_version = rd_rec.version;
                     end else if (tick_phase == sdo_pkg::PH_WRITING) begin
                        want_emit  = 1'b1;
                        emit_kind  = sdo_pkg::KIND_WR_REQ;
                        emit_index = rd_rec.key[23:8];
                        emit_sub   = rd_rec.key[7:0];
                        emit_size  = rd_rec.size;
                        emit_value = rd_rec.data & sdo_pkg::size_mask(rd_rec.size);
                     end else begin
                        want_emit  = 1'b1;
                        emit_kind  = sdo_pkg::KIND_READ_REQ;
                        emit_index = rd_rec.key[23:8];
                        emit_sub   = rd_rec.key[7:0];
                     end
                  end
               end
               default: begin
                  // device responses, matched on the first live entry with the key
                  if (key_hit) begin
                     want_emit = 1'b1;
                     do_wr     = 1'b1;
                     if (busy) begin
                        if (op_ff == sdo_pkg::OP_READ_OK) begin
                           if (rd_rec.phase == sdo_pkg::PH_READING) begin
                              new_rec.data    = resp_val;
                              new_rec.version = (ver_inc == 32'd0) ? 32'd1 : ver_inc;
                              new_rec.phase   = sdo_pkg::PH_SUCCESS;
                           end else if (rd_rec.phase == sdo_pkg::PH_CONFIRM) begin
                              new_rec.phase = (resp_val == (rd_rec.data & resp_mask)) ?
                                              sdo_pkg::PH_SUCCESS : sdo_pkg::PH_WRITING;
                           end
                        end else if (rd_rec.phase == sdo_pkg::PH_WRITING) begin
                           if (op_ff == sdo_pkg::OP_WRITE_OK) begin
                              new_rec.phase = sdo_pkg::PH_SUCCESS;
                           end else if (op_ff == sdo_pkg::OP_WRITE_FAIL) begin
                              new_rec.phase = sdo_pkg::PH_CONFIRM;
                           end
                        end
                     end
                  end
               end
            endcase

            ram_wr.rec = new_rec;
            if (!want_emit || out_free) begin
               ram_wr.en = do_wr;
               emit_en   = want_emit;
               if (op_ff == sdo_pkg::OP_DEFINE) begin
                  if (!sweep_ff) begin
                     state_in = sdo_pkg::S_IDLE;
                  end else if (ptr_ff == LAST_PTR) begin
                     sweep_in = 1'b0;
                     ptr_in   = AW'(id_ff);
                     state_in = sdo_pkg::S_READ;
                  end else begin
                     ptr_in   = ptr_ff + AW'(1);
                     state_in = sdo_pkg::S_READ;
                  end
               end else if (op_ff == sdo_pkg::OP_READ || op_ff == sdo_pkg::OP_WRITE) begin
                  state_in = sdo_pkg::S_IDLE;
               end else if (op_ff != sdo_pkg::OP_TICK && key_hit) begin
                  state_in = sdo_pkg::S_IDLE;
               end else if (ptr_ff == LAST_PTR) begin
                  reply_kind_in = (op_ff == sdo_pkg::OP_TICK) ?
                                  sdo_pkg::KIND_FLUSH : sdo_pkg::KIND_UNKNOWN;
                  state_in      = sdo_pkg::S_REPLY;
               end else begin
                  ptr_in   = ptr_ff + AW'(1);
                  state_in = sdo_pkg::S_READ;
               end
            end
         end

         sdo_pkg::S_REPLY: begin
            emit_kind  = reply_kind_ff;
            emit_entry = (reply_kind_ff == sdo_pkg::KIND_BAD) ? id_ff : 5'd0;
            if (out_free) begin
               emit_en  = 1'b1;
               state_in = sdo_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = sdo_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sdo_pkg::S_IDLE;
         ptr_ff        <= '0;
         sweep_ff      <= 1'b0;
         reply_kind_ff <= sdo_pkg::KIND_ACK;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         sweep_ff      <= sweep_in;
         reply_kind_ff <= reply_kind_in;
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // captured item and result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff      <= req_operation;
         id_ff      <= req_entry_id;
         key_ff     <= {req_obj_index, req_obj_subindex};
         size_ff    <= req_size_code;
         masked_ff  <= req_masked;
         data_ff    <= req_data_value;
         checked_ff <= req_checked;
      end
      if (emit_en) begin
         rsp_kind_ff    <= emit_kind;
         rsp_entry_ff   <= emit_entry;
         rsp_index_ff   <= emit_index;
         rsp_sub_ff     <= emit_sub;
         rsp_size_ff    <= emit_size;
         rsp_value_ff   <= emit_value;
         rsp_version_ff <= emit_version;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_result_entry = rsp_entry_ff;
   assign rsp_req_index    = rsp_index_ff;
   assign rsp_req_subindex = rsp_sub_ff;
   assign rsp_req_size     = rsp_size_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_version  = rsp_version_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef ASSERT_OFF
   // the memory is only written while an item is being worked
   a_no_wr_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdo_pkg::S_IDLE) |-> !ram_wr.en)
      else $error("entry write while idle");

   // tick results per entry are never the last of the run
   a_tick_not_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == sdo_pkg::KIND_READ_REQ ||
                     rsp_kind == sdo_pkg::KIND_WR_REQ ||
                     rsp_kind == sdo_pkg::KIND_COMPLETE)) |-> !rsp_last)
      else $error("per-entry tick result marked last");

   // an accepted item always occupies the sequencer
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_ready)
      else $error("ready right after accept");

   // walk pointer stays inside the table
   a_ptr_range : assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= LAST_PTR)
      else $error("entry pointer out of range");
`endif

endmodule
